@@ design/cabac_pkg.sv @@
// Package: shared constants, action codes and probability tables for the CABAC decoder.
`default_nettype none
package cabac_pkg;

  localparam int unsigned CtxCountDefault = 256;
  localparam int unsigned FifoDepthDefault = 16;
  localparam logic [5:0] QpReset = 6'd26;

  typedef enum logic [2:0] {
    ACT_FEED   = 3'd0,
    ACT_START  = 3'd1,
    ACT_INIT   = 3'd2,
    ACT_CTX    = 3'd3,
    ACT_BYP    = 3'd4,
    ACT_BYPN   = 3'd5,
    ACT_LEVEL  = 3'd6,
    ACT_NOP    = 3'd7
  } action_e;

  function automatic logic [7:0] lps_range(input logic [5:0] st, input logic [1:0] col);
    logic [31:0] row;
    begin
      case (st)
        6'd0: row = {8'd240, 8'd208, 8'd176, 8'd128};
        6'd1: row = {8'd227, 8'd197, 8'd167, 8'd128};
        6'd2: row = {8'd216, 8'd187, 8'd158, 8'd128};
        6'd3: row = {8'd205, 8'd178, 8'd150, 8'd123};
        6'd4: row = {8'd195, 8'd169, 8'd142, 8'd116};
        6'd5: row = {8'd185, 8'd160, 8'd135, 8'd111};
        6'd6: row = {8'd175, 8'd152, 8'd128, 8'd105};
        6'd7: row = {8'd166, 8'd144, 8'd122, 8'd100};
        6'd8: row = {8'd158, 8'd137, 8'd116, 8'd95};
        6'd9: row = {8'd150, 8'd130, 8'd110, 8'd90};
        6'd10: row = {8'd142, 8'd123, 8'd104, 8'd85};
        6'd11: row = {8'd135, 8'd117, 8'd99, 8'd81};
        6'd12: row = {8'd128, 8'd111, 8'd94, 8'd77};
        6'd13: row = {8'd122, 8'd105, 8'd89, 8'd73};
        6'd14: row = {8'd116, 8'd100, 8'd85, 8'd69};
        6'd15: row = {8'd110, 8'd95, 8'd80, 8'd66};
        6'd16: row = {8'd104, 8'd90, 8'd76, 8'd62};
        6'd17: row = {8'd99, 8'd86, 8'd72, 8'd59};
        6'd18: row = {8'd94, 8'd81, 8'd69, 8'd56};
        6'd19: row = {8'd89, 8'd77, 8'd65, 8'd53};
        6'd20: row = {8'd85, 8'd73, 8'd62, 8'd51};
        6'd21: row = {8'd80, 8'd69, 8'd59, 8'd48};
        6'd22: row = {8'd76, 8'd66, 8'd56, 8'd46};
        6'd23: row = {8'd72, 8'd63, 8'd53, 8'd43};
        6'd24: row = {8'd69, 8'd59, 8'd50, 8'd41};
        6'd25: row = {8'd65, 8'd56, 8'd48, 8'd39};
        6'd26: row = {8'd62, 8'd54, 8'd45, 8'd37};
        6'd27: row = {8'd59, 8'd51, 8'd43, 8'd35};
        6'd28: row = {8'd56, 8'd48, 8'd41, 8'd33};
        6'd29: row = {8'd53, 8'd46, 8'd39, 8'd32};
        6'd30: row = {8'd50, 8'd43, 8'd37, 8'd30};
        6'd31: row = {8'd48, 8'd41, 8'd35, 8'd29};
        6'd32: row = {8'd45, 8'd39, 8'd33, 8'd27};
        6'd33: row = {8'd43, 8'd37, 8'd31, 8'd26};
        6'd34: row = {8'd41, 8'd35, 8'd30, 8'd24};
        6'd35: row = {8'd39, 8'd33, 8'd28, 8'd23};
        6'd36: row = {8'd37, 8'd32, 8'd27, 8'd22};
        6'd37: row = {8'd35, 8'd30, 8'd26, 8'd21};
        6'd38: row = {8'd33, 8'd29, 8'd24, 8'd20};
        6'd39: row = {8'd31, 8'd27, 8'd23, 8'd19};
        6'd40: row = {8'd30, 8'd26, 8'd22, 8'd18};
        6'd41: row = {8'd28, 8'd25, 8'd21, 8'd17};
        6'd42: row = {8'd27, 8'd23, 8'd20, 8'd16};
        6'd43: row = {8'd25, 8'd22, 8'd19, 8'd15};
        6'd44: row = {8'd24, 8'd21, 8'd18, 8'd14};
        6'd45: row = {8'd23, 8'd20, 8'd17, 8'd14};
        6'd46: row = {8'd22, 8'd19, 8'd16, 8'd13};
        6'd47: row = {8'd21, 8'd18, 8'd15, 8'd12};
        6'd48: row = {8'd20, 8'd17, 8'd14, 8'd12};
        6'd49: row = {8'd19, 8'd16, 8'd14, 8'd11};
        6'd50: row = {8'd18, 8'd15, 8'd13, 8'd11};
        6'd51: row = {8'd17, 8'd15, 8'd12, 8'd10};
        6'd52: row = {8'd16, 8'd14, 8'd12, 8'd10};
        6'd53: row = {8'd15, 8'd13, 8'd11, 8'd9};
        6'd54: row = {8'd14, 8'd12, 8'd11, 8'd9};
        6'd55: row = {8'd14, 8'd12, 8'd10, 8'd8};
        6'd56: row = {8'd13, 8'd11, 8'd9, 8'd8};
        6'd57: row = {8'd12, 8'd11, 8'd9, 8'd7};
        6'd58: row = {8'd12, 8'd10, 8'd9, 8'd7};
        6'd59: row = {8'd11, 8'd10, 8'd8, 8'd7};
        6'd60: row = {8'd11, 8'd9, 8'd8, 8'd6};
        6'd61: row = {8'd10, 8'd9, 8'd7, 8'd6};
        6'd62: row = {8'd9, 8'd8, 8'd7, 8'd6};
        default: row = {8'd2, 8'd2, 8'd2, 8'd2};
      endcase
      return row[col*8 +: 8];
    end
  endfunction

  function automatic logic [2:0] lps_shift(input logic [4:0] i);
    begin
      if (i == 5'd0) return 3'd6;
      else if (i == 5'd1) return 3'd5;
      else if (i <= 5'd3) return 3'd4;
      else if (i <= 5'd7) return 3'd3;
      else if (i <= 5'd15) return 3'd2;
      else return 3'd1;
    end
  endfunction

  function automatic logic [5:0] after_lps(input logic [5:0] st);
    logic [5:0] r;
    begin
      case (st)
        6'd0, 6'd1: r = 6'd0;
        6'd2: r = 6'd1;
        6'd3, 6'd4: r = 6'd2;
        6'd5, 6'd6: r = 6'd4;
        6'd7: r = 6'd5;
        6'd8: r = 6'd6;
        6'd9: r = 6'd7;
        6'd10: r = 6'd8;
        6'd11, 6'd12: r = 6'd9;
        6'd13, 6'd14: r = 6'd11;
        6'd15: r = 6'd12;
        6'd16, 6'd17: r = 6'd13;
        6'd18, 6'd19: r = 6'd15;
        6'd20, 6'd21: r = 6'd16;
        6'd22, 6'd23: r = 6'd18;
        6'd24, 6'd25: r = 6'd19;
        6'd26, 6'd27: r = 6'd21;
        6'd28, 6'd29: r = 6'd22;
        6'd30: r = 6'd23;
        6'd31, 6'd32: r = 6'd24;
        6'd33: r = 6'd25;
        6'd34, 6'd35: r = 6'd26;
        6'd36, 6'd37: r = 6'd27;
        6'd38: r = 6'd28;
        6'd39, 6'd40: r = 6'd29;
        6'd41, 6'd42, 6'd43: r = 6'd30;
        6'd44: r = 6'd31;
        6'd45, 6'd46: r = 6'd32;
        6'd47, 6'd48, 6'd49: r = 6'd33;
        6'd50, 6'd51: r = 6'd34;
        6'd52, 6'd53, 6'd54: r = 6'd35;
        6'd55, 6'd56, 6'd57: r = 6'd36;
        6'd58, 6'd59, 6'd60: r = 6'd37;
        6'd61, 6'd62: r = 6'd38;
        default: r = 6'd63;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

@@ design/cabac_fifo.sv @@
// Byte FIFO feeding the arithmetic decoder.
`default_nettype none
module cabac_fifo #(
  parameter int unsigned FifoDepth = cabac_pkg::FifoDepthDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire logic [7:0] push_data_i,
  input  wire logic       pop_i,
  output logic [7:0]      pop_data_o,
  output logic            empty_o,
  output logic            full_o
);
  import cabac_pkg::*;

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  logic [7:0] mem_q [FifoDepth];
  logic [PtrW-1:0] rd_q, wr_q;
  logic [CntW-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o = (cnt_q == CntW'(FifoDepth));
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
      wr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i) rd_q <= (rd_q == PtrW'(FifoDepth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end
endmodule
`default_nettype wire

@@ design/cabac_binary_arithmetic_decoder.sv @@
// Top level: CABAC arithmetic decoding engine with byte FIFO and context memory.
//
// Usage: present an item on start with the fields while busy is low. The
// result appears with done_o high for exactly one cycle; it cannot be held off.
// The quantizer register is written through cfg_valid_i/cfg_ready_o while idle.
// Steps, accept to result (each item ends in S_RD, which raises done_o):
//   feed pushes the byte; start pops one FIFO byte at accept and one more after; ctx init
//   multiplies, then writes; ctx bin does memory read, range and renorm with write back,
//   read back; bypass takes one step; bypass bits and level remaining take one per bin.
// The next item can be accepted in the cycle after done_o.
// The shared bypass step (shift, refill, compare-subtract) is run once a cycle
// by the sequencer for every bypass bin, so multi-bin items take one cycle per bin.
// After reset the context memory is swept to zero, one entry a cycle, over
// all 256 entries while busy is high; range, offset, counter and FIFO pointers
// are cleared at once and the quantizer register returns to 26.
`default_nettype none
module cabac_binary_arithmetic_decoder #(
  parameter int unsigned FIFO_DEPTH = cabac_pkg::FifoDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  output logic             done_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [5:0]  cfg_data_i,
  input  wire logic [2:0]  action_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [7:0]  context_index_i,
  input  wire logic [7:0]  init_value_i,
  input  wire logic [2:0]  rice_param_i,
  input  wire logic [5:0]  bit_count_i,
  output logic [34:0]      decoded_value_o,
  output logic             fifo_dry_o,
  output logic             fifo_overflow_o,
  output logic [8:0]       range_now_o,
  output logic [23:0]      offset_now_o,
  output logic signed [3:0] bits_pending_o,
  output logic [5:0]       ctx_state_now_o,
  output logic             ctx_mps_now_o
);
  import cabac_pkg::*;

  localparam int unsigned CtxCount = CtxCountDefault;
  localparam int unsigned CtxW = (CtxCount > 1) ? $clog2(CtxCount) : 1;
  localparam int unsigned SweepW = $clog2(CtxCount + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_START2, S_RD, S_CTX, S_INIT2, S_WB, S_BYP, S_DONE
  } state_e;

  typedef enum logic [1:0] {
    M_ONE, M_RUN, M_PREFIX, M_SUFFIX
  } mode_e;

  state_e state_q;
  mode_e mode_q;
  logic [5:0] qp_q;
  logic [8:0] range_q;
  logic [23:0] offset_q;
  logic signed [3:0] bc_q;
  logic [34:0] val_q;
  logic dry_q, ovf_q;
  logic [2:0] act_q;
  logic [CtxW-1:0] idx_q;
  logic [7:0] iv_q;
  logic [2:0] rice_q;
  logic [5:0] left_q;
  logic [5:0] prefix_q;
  logic [SweepW-1:0] sweep_q;
  logic [6:0] ctx_q;
  logic [6:0] rd_q;
  logic signed [11:0] prod_q;
  logic signed [7:0] offs_q;

  logic [6:0] ctx_mem [CtxCount];
  logic [CtxW-1:0] rd_addr;
  logic wr_en;
  logic [CtxW-1:0] wr_addr;
  logic [6:0] wr_data;

  logic f_push, f_pop, f_empty, f_full;
  logic [7:0] f_data;

  cabac_fifo #(.FifoDepth(FIFO_DEPTH)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(f_push), .push_data_i(data_byte_i),
    .pop_i(f_pop), .pop_data_o(f_data),
    .empty_o(f_empty), .full_o(f_full)
  );

  assign busy = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign f_push = start && !busy && (action_e'(action_i) == ACT_FEED) && !f_full;

  logic [CtxW-1:0] in_idx;
  assign in_idx = CtxW'(context_index_i % CtxCount);
  assign rd_addr = (state_q == S_IDLE) ? in_idx : idx_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) ctx_mem[wr_addr] <= wr_data;
    rd_q <= ctx_mem[rd_addr];
  end

  // bypass step
  logic [23:0] b_sh;
  logic signed [3:0] b_bc;
  logic b_refill;
  logic [23:0] b_or;
  logic [23:0] b_scaled;
  logic b_bit;
  logic [23:0] b_off;
  always_comb begin
    b_sh = {offset_q[22:0], 1'b0};
    b_bc = bc_q + 4'sd1;
    b_refill = !b_bc[3];
    b_or = b_refill ? (b_sh | {16'd0, (f_empty ? 8'd0 : f_data)}) : b_sh;
    b_scaled = {8'd0, range_q, 7'd0};
    b_bit = (b_or >= b_scaled);
    b_off = b_bit ? b_or - b_scaled : b_or;
  end

  // context bin datapath
  logic [5:0] c_st;
  logic c_mps;
  logic [7:0] c_lps;
  logic [8:0] c_rng;
  logic [15:0] c_scaled;
  logic c_is_mps;
  logic [2:0] c_nb;
  logic [23:0] c_off_l;
  logic signed [4:0] c_bc_l;
  logic [23:0] c_byte_sh;
  always_comb begin
    c_st = ctx_q[5:0];
    c_mps = ctx_q[6];
    c_lps = lps_range(c_st, range_q[7:6]);
    c_rng = range_q - {1'b0, c_lps};
    c_scaled = {c_rng, 7'd0};
    c_is_mps = (offset_q < {8'd0, c_scaled});
    c_nb = lps_shift(c_lps[7:3]);
    c_off_l = (offset_q - {8'd0, c_scaled}) << c_nb;
    c_bc_l = 5'(bc_q) + 5'(c_nb);
    c_byte_sh = {16'd0, (f_empty ? 8'd0 : f_data)} << c_bc_l[2:0];
  end

  // context init arithmetic
  logic signed [7:0] i_slope;
  logic signed [6:0] i_qpm;
  logic [5:0] i_qp;
  logic signed [7:0] i_q;
  logic signed [11:0] i_s;
  always_comb begin
    i_slope = $signed(8'({4'd0, iv_q[7:4]} * 8'd5)) - 8'sd45;
    i_qp = (qp_q > 6'd51) ? 6'd51 : qp_q;
    i_qpm = $signed({1'b0, i_qp}) - 7'sd16;
    i_q = 8'(prod_q >>> 4);
    i_s = 12'(i_q) + 12'(offs_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      mode_q <= M_ONE;
      qp_q <= QpReset;
      range_q <= '0;
      offset_q <= '0;
      bc_q <= '0;
      sweep_q <= '0;
      done_o <= 1'b0;
      val_q <= '0;
      dry_q <= 1'b0;
      ovf_q <= 1'b0;
      act_q <= '0;
      idx_q <= '0;
      iv_q <= '0;
      rice_q <= '0;
      left_q <= '0;
      prefix_q <= '0;
      ctx_q <= '0;
      prod_q <= '0;
      offs_q <= '0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == SweepW'(CtxCount - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (cfg_valid_i) qp_q <= cfg_data_i;
          if (start) begin
            act_q <= action_i;
            idx_q <= in_idx;
            iv_q <= init_value_i;
            rice_q <= (rice_param_i > 3'd4) ? 3'd4 : rice_param_i;
            left_q <= (bit_count_i > 6'd32) ? 6'd32 : bit_count_i;
            val_q <= '0;
            dry_q <= (action_e'(action_i) == ACT_START) && f_empty;
            ovf_q <= (action_e'(action_i) == ACT_FEED) && f_full;
            prefix_q <= '0;
            case (action_e'(action_i))
              ACT_FEED: begin
                state_q <= S_RD;
              end
              ACT_START: begin
                range_q <= 9'd510;
                offset_q <= {8'd0, (f_empty ? 8'd0 : f_data), 8'd0};
                state_q <= S_START2;
              end
              ACT_BYP: begin
                mode_q <= M_ONE;
                state_q <= S_BYP;
              end
              ACT_BYPN: begin
                mode_q <= M_RUN;
                state_q <= (bit_count_i == 6'd0) ? S_RD : S_BYP;
              end
              ACT_LEVEL: begin
                mode_q <= M_PREFIX;
                state_q <= S_BYP;
              end
              ACT_INIT: state_q <= S_CTX;
              ACT_CTX: state_q <= S_RD;
              default: state_q <= S_RD;
            endcase
          end
        end
        S_START2: begin
          if (f_empty) begin
            dry_q <= 1'b1;
            bc_q <= 4'sd0;
          end else begin
            offset_q <= offset_q | {16'd0, f_data};
            bc_q <= -4'sd8;
          end
          state_q <= S_RD;
        end
        S_CTX: begin
          // init: multiply stage
          prod_q <= 12'(i_slope) * 12'(i_qpm);
          offs_q <= $signed({1'b0, iv_q[3:0], 3'd0}) - 8'sd16;
          state_q <= (action_e'(act_q) == ACT_INIT) ? S_INIT2 : S_RD;
        end
        S_INIT2: begin
          state_q <= S_RD;
        end
        S_RD: begin
          if (action_e'(act_q) == ACT_CTX && mode_q != M_SUFFIX) begin
            ctx_q <= rd_q;
            mode_q <= M_SUFFIX;
            state_q <= S_WB;
          end else begin
            done_o <= 1'b1;
            state_q <= S_DONE;
          end
        end
        S_WB: begin
          if (c_is_mps) begin
            val_q <= {34'd0, c_mps};
            if (c_rng[8] == 1'b0) begin
              range_q <= {c_rng[7:0], 1'b0};
              if (b_refill) begin
                bc_q <= -4'sd8;
                offset_q <= {offset_q[22:0], 1'b0} | {16'd0, (f_empty ? 8'd0 : f_data)};
                dry_q <= f_empty;
              end else begin
                offset_q <= {offset_q[22:0], 1'b0};
                bc_q <= b_bc;
              end
            end else begin
              range_q <= c_rng;
            end
          end else begin
            val_q <= {34'd0, ~c_mps};
            range_q <= 9'({c_lps, 1'b0} << (c_nb - 3'd1));
            if (!c_bc_l[4]) begin
              offset_q <= c_off_l | c_byte_sh;
              bc_q <= 4'(c_bc_l - 5'sd8);
              dry_q <= f_empty;
            end else begin
              offset_q <= c_off_l;
              bc_q <= c_bc_l[3:0];
            end
          end
          state_q <= S_RD;
        end
        S_BYP: begin
          offset_q <= b_off;
          bc_q <= b_refill ? -4'sd8 : b_bc;
          if (b_refill && f_empty) dry_q <= 1'b1;
          case (mode_q)
            M_ONE: begin
              val_q <= {34'd0, b_bit};
              state_q <= S_RD;
            end
            M_RUN, M_SUFFIX: begin
              val_q <= {val_q[33:0], b_bit};
              left_q <= left_q - 6'd1;
              if (left_q == 6'd1) state_q <= S_RD;
            end
            M_PREFIX: begin
              if (b_bit && prefix_q < 6'd32) begin
                prefix_q <= prefix_q + 6'd1;
              end else if (prefix_q <= 6'd3) begin
                val_q <= 35'(prefix_q) << rice_q;
                left_q <= {3'd0, rice_q};
                mode_q <= M_SUFFIX;
                if (rice_q == 3'd0) state_q <= S_RD;
              end else begin
                val_q <= ((35'd1 << (prefix_q - 6'd3)) + 35'd2) << rice_q;
                left_q <= prefix_q - 6'd3 + 6'(rice_q);
                mode_q <= M_SUFFIX;
              end
            end
            default: state_q <= S_RD;
          endcase
        end
        S_DONE: begin
          done_o <= 1'b0;
          mode_q <= M_ONE;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // suffix accumulation adds onto the level base: fold by tracking separately
  logic [34:0] base_q;
  logic [34:0] suf_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      suf_q <= '0;
    end else if (state_q == S_IDLE) begin
      base_q <= '0;
      suf_q <= '0;
    end else if (state_q == S_BYP && mode_q == M_PREFIX && !(b_bit && prefix_q < 6'd32)) begin
      base_q <= (prefix_q <= 6'd3) ? (35'(prefix_q) << rice_q)
                : (((35'd1 << (prefix_q - 6'd3)) + 35'd2) << rice_q);
    end else if (state_q == S_BYP && mode_q == M_SUFFIX) begin
      suf_q <= {suf_q[33:0], b_bit};
    end
  end

  // FIFO pops
  always_comb begin
    f_pop = 1'b0;
    if (!f_empty) begin
      case (state_q)
        S_IDLE: f_pop = start && (action_e'(action_i) == ACT_START);
        S_START2: f_pop = 1'b1;
        S_BYP: f_pop = b_refill;
        S_WB: f_pop = c_is_mps ? (!c_rng[8] && b_refill) : !c_bc_l[4];
        default: f_pop = 1'b0;
      endcase
    end
  end

  // context memory write: sweep, init or bin update
  logic [5:0] u_st;
  logic u_mps;
  logic [6:0] init_entry;
  logic [6:0] i_sc;
  always_comb begin
    i_sc = (i_s < 12'sd1) ? 7'd1 : (i_s > 12'sd126) ? 7'd126 : i_s[6:0];
    init_entry = (i_sc >= 7'd64) ? {1'b1, 6'(i_sc - 7'd64)} : {1'b0, 6'(7'd63 - i_sc)};
    if (c_is_mps) begin
      u_mps = c_mps;
      u_st = (c_st < 6'd62) ? c_st + 6'd1 : c_st;
    end else begin
      u_mps = (c_st == 6'd0) ? ~c_mps : c_mps;
      u_st = after_lps(c_st);
    end
    wr_en = 1'b0;
    wr_addr = idx_q;
    wr_data = init_entry;
    case (state_q)
      S_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = sweep_q[CtxW-1:0];
        wr_data = '0;
      end
      S_INIT2: wr_en = 1'b1;
      S_WB: begin
        wr_en = 1'b1;
        wr_data = {u_mps, u_st};
      end
      default: wr_en = 1'b0;
    endcase
  end

  assign decoded_value_o = (action_e'(act_q) == ACT_LEVEL) ? base_q + suf_q : val_q;
  assign fifo_dry_o = dry_q;
  assign fifo_overflow_o = ovf_q;
  assign range_now_o = range_q;
  assign offset_now_o = offset_q;
  assign bits_pending_o = bc_q;
  assign ctx_state_now_o = rd_q[5:0];
  assign ctx_mps_now_o = rd_q[6];
endmodule
`default_nettype wire

@@ design/cabac_checker.sv @@
// Port-level checker for the CABAC decoder, bound to the top level.
`default_nettype none
module cabac_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done_o,
  input wire logic        cfg_ready_o,
  input wire logic [8:0]  range_now_o,
  input wire logic [3:0]  bits_pending_o
);
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held two cycles");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("done while idle");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !busy) else $error("config ready while busy");
  a_range_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && $past(!busy)) |-> $stable(range_now_o) && $stable(bits_pending_o))
    else $error("coder state moved while idle");
endmodule

bind cabac_binary_arithmetic_decoder cabac_checker u_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .cfg_ready_o,
  .range_now_o, .bits_pending_o
);
`default_nettype wire
